// ===== sv/oaht_pkg.sv =====
`default_nettype none

package oaht_pkg;

    // table geometry, slot count must be a power of two
    localparam int TableSlots = 8;
    localparam int SlotW      = $clog2(TableSlots);
    localparam int KeyW       = 31;
    localparam int CmdW       = 2;
    localparam int StatusW    = 2;
    localparam int OutSlotW   = 3;
    localparam int MarkW      = 2;
    localparam int EntryW     = MarkW + KeyW;

    typedef logic [SlotW-1:0] t_slot;
    typedef logic [KeyW-1:0]  t_key;

    typedef enum logic [CmdW-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [MarkW-1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_TOMB  = 2'd2,
        MARK_SPARE = 2'd3
    } t_mark;

    typedef enum logic [StatusW-1:0] {
        ST_OK       = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_RESERVED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_REJECT
    } t_state;

    // one slot entry as held in the slot memory
    typedef struct packed {
        t_mark mark;
        t_key  key;
    } t_entry;

endpackage

`default_nettype wire

// ===== sv/open_address_hash_table_core.sv =====
`default_nettype none

// Hash table with linear probing and tombstones over oaht_pkg::TableSlots slots (8).
// Each request (insert, delete or search on a 31-bit key) gives exactly one result:
// a status (0 done or found, 1 key not present, 2 table full) and a slot, which is
// the slot touched when the status is 0 and zero otherwise. One request is worked
// at a time. The slot store is a single-port synchronous memory with registered
// read data; the probe reads one slot per cycle, starting at the key's home slot
// (key modulo the slot count) and wrapping, so a request probes at most TableSlots
// slots, and a request with an unknown command gets status 1. A finished result
// sits in an output register, so the next request is accepted while it waits.
// Slot marks read as empty after reset through per-slot valid flags; no clearing
// pass is needed.
module open_address_hash_table_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [30:0] key, [31] zero
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] command
    // result side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [2:0] slot, [7:3] zero
    output logic [1:0]       m_axis_tuser   // [1:0] status
);

    localparam int Slots = oaht_pkg::TableSlots;

    // slot memory and per-slot written flags
    oaht_pkg::t_entry mem [Slots];
    logic [Slots-1:0]  r_valid;
    oaht_pkg::t_entry  r_rd_data;

    oaht_pkg::t_state  r_state, n_state;
    oaht_pkg::t_cmd    r_cmd;
    oaht_pkg::t_key    r_key;
    oaht_pkg::t_slot   r_addr, n_addr, addr_next;
    oaht_pkg::t_slot   r_cnt;

    logic              r_o_valid;
    oaht_pkg::t_status r_o_status;
    logic [2:0]        r_o_slot;

    logic              in_acc;
    logic              out_free;
    logic              fin;
    logic              wr_en;
    oaht_pkg::t_entry  wr_data;
    oaht_pkg::t_status fin_status;
    oaht_pkg::t_mark   cur_mark;
    logic              last_probe;
    oaht_pkg::t_slot   home;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_o_valid || m_axis_tready;
    assign home      = oaht_pkg::t_slot'(s_axis_tdata[oaht_pkg::SlotW-1:0]);
    assign addr_next = (r_addr == oaht_pkg::t_slot'(Slots - 1))
                       ? '0 : r_addr + oaht_pkg::t_slot'(1);
    assign last_probe = (r_cnt == oaht_pkg::t_slot'(Slots - 1));
    // a slot never written reads as empty
    assign cur_mark  = r_valid[r_addr] ? r_rd_data.mark : oaht_pkg::MARK_EMPTY;

    // probe decision for the slot just read
    always_comb begin
        fin        = 1'b0;
        wr_en      = 1'b0;
        fin_status = oaht_pkg::ST_ABSENT;
        wr_data    = r_rd_data;
        if (r_cmd == oaht_pkg::CMD_INSERT) begin
            if (cur_mark != oaht_pkg::MARK_USED) begin
                fin        = 1'b1;
                wr_en      = 1'b1;
                fin_status = oaht_pkg::ST_OK;
                wr_data    = '{mark: oaht_pkg::MARK_USED, key: r_key};
            end else if (last_probe) begin
                fin        = 1'b1;
                fin_status = oaht_pkg::ST_FULL;
            end
        end else begin
            if (cur_mark == oaht_pkg::MARK_EMPTY) begin
                fin = 1'b1;
            end else if (cur_mark == oaht_pkg::MARK_USED && r_rd_data.key == r_key) begin
                fin        = 1'b1;
                fin_status = oaht_pkg::ST_OK;
                wr_en      = (r_cmd == oaht_pkg::CMD_DELETE);
                wr_data    = '{mark: oaht_pkg::MARK_TOMB, key: r_rd_data.key};
            end else if (last_probe) begin
                fin = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oaht_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (oaht_pkg::t_cmd'(s_axis_tuser) == oaht_pkg::CMD_NONE) begin
                        n_state = oaht_pkg::S_REJECT;
                    end else begin
                        n_state = oaht_pkg::S_PROBE;
                    end
                end
            end
            oaht_pkg::S_PROBE: begin
                if (fin && out_free) begin
                    n_state = oaht_pkg::S_IDLE;
                end
            end
            oaht_pkg::S_REJECT: begin
                if (out_free) begin
                    n_state = oaht_pkg::S_IDLE;
                end
            end
            default: n_state = oaht_pkg::S_IDLE;
        endcase
    end

    // outputs of the state machine: ready and read address
    always_comb begin
        s_axis_tready = 1'b0;
        n_addr        = r_addr;
        unique case (r_state)
            oaht_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                n_addr        = home;
            end
            oaht_pkg::S_PROBE: begin
                if (!fin) begin
                    n_addr = addr_next;
                end
            end
            oaht_pkg::S_REJECT: begin
                n_addr = r_addr;
            end
            default: n_addr = r_addr;
        endcase
    end

    // slot memory, read data registered
    always_ff @(posedge i_clk) begin
        if (r_state == oaht_pkg::S_PROBE && fin && out_free && wr_en) begin
            mem[r_addr] <= wr_data;
        end
        r_rd_data <= mem[n_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= oaht_pkg::S_IDLE;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == oaht_pkg::S_PROBE && fin && out_free && wr_en) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (r_state == oaht_pkg::S_PROBE && fin && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_state == oaht_pkg::S_REJECT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (in_acc) begin
            r_cmd <= oaht_pkg::t_cmd'(s_axis_tuser);
            r_key <= s_axis_tdata[oaht_pkg::KeyW-1:0];
            r_cnt <= '0;
        end else if (r_state == oaht_pkg::S_PROBE && !fin) begin
            r_cnt <= r_cnt + oaht_pkg::t_slot'(1);
        end
        if (r_state == oaht_pkg::S_PROBE && fin && out_free) begin
            r_o_status <= fin_status;
            r_o_slot   <= (fin_status == oaht_pkg::ST_OK) ? 3'(r_addr) : 3'd0;
        end else if (r_state == oaht_pkg::S_REJECT && out_free) begin
            r_o_status <= oaht_pkg::ST_ABSENT;
            r_o_slot   <= 3'd0;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {5'd0, r_o_slot};
    assign m_axis_tuser  = r_o_status;

endmodule

`default_nettype wire
